// ===== design/loc_pkg.sv =====
// Package for the linear octree coarsening unit: field widths, configuration
// register indexes, the command type passed from front to back, and the
// configuration struct. No dependencies.
package loc_pkg;

  localparam int LEVEL_BITS    = 5;
  localparam int DIM_BITS      = 2;
  localparam int DEPTH_BITS    = 5;
  localparam int CNT_BITS      = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 5;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DIMENSION = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DEPTH = 2'd1;

  localparam logic [DIM_BITS-1:0]   DIM_QUADTREE    = 2'd2;
  localparam logic [DIM_BITS-1:0]   DIM_RESET       = 2'd3;
  localparam logic [DEPTH_BITS-1:0] MAX_DEPTH_RESET = 5'd16;

  // Work the back end carries out for one accepted octant
  typedef enum logic [1:0] {
    OP_PASS,
    OP_HOLD,
    OP_PARENT
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [CNT_BITS-1:0] flush_cnt;  // held entries to emit before the op
    logic [CNT_BITS-1:0] slot;       // held entry written by a hold
    logic                eot;        // last octant of the tree
  } ctrl_t;

  typedef struct packed {
    logic [DIM_BITS-1:0]   dimension;
    logic [DEPTH_BITS-1:0] max_depth;
  } cfg_t;

endpackage

// ===== design/loc_in_if.sv =====
// Input octant channel: valid/ready handshake with the octant payload.
// Depends on loc_pkg for the level width.
interface loc_in_if #(parameter int COORD_BITS = 16);
  logic                           valid;
  logic                           ready;
  logic [COORD_BITS-1:0]          coord_x;
  logic [COORD_BITS-1:0]          coord_y;
  logic [COORD_BITS-1:0]          coord_z;
  logic [loc_pkg::LEVEL_BITS-1:0] level;
  logic                           end_of_tree;

  modport source (output valid, coord_x, coord_y, coord_z, level, end_of_tree,
                  input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, level, end_of_tree,
                  output ready);
endinterface

// ===== design/loc_out_if.sv =====
// Result octant channel: valid/ready handshake with the emitted octant.
// Depends on loc_pkg for the level width.
interface loc_out_if #(parameter int COORD_BITS = 16);
  logic                           valid;
  logic                           ready;
  logic [COORD_BITS-1:0]          out_x;
  logic [COORD_BITS-1:0]          out_y;
  logic [COORD_BITS-1:0]          out_z;
  logic [loc_pkg::LEVEL_BITS-1:0] out_level;
  logic                           merged;
  logic                           final_out;

  modport source (output valid, out_x, out_y, out_z, out_level, merged, final_out,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_level, merged, final_out,
                  output ready);
endinterface

// ===== design/loc_cfg_if.sv =====
// Configuration write channel: valid/ready with register index and data.
// Depends on loc_pkg for the index and data widths.
interface loc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [loc_pkg::CFG_IDX_BITS-1:0]  index;
  logic [loc_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/linear_octree_coarsen_unit.sv =====
// Linear octree coarsening unit, top level.
// Depends on loc_pkg, loc_in_if, loc_out_if, loc_cfg_if, loc_queue,
// loc_front and loc_back.
//
// Use: stream a sorted, complete linear octree into in_i, one octant per
// transaction, with end_of_tree set on its last octant. Complete sibling
// runs leave out_o as one parent with merged set; everything else leaves
// unchanged and in order. final_out marks the last result of a tree.
// cfg_i writes dimension (index 0) and max_depth (index 1); it is always ready.
// Write it only while the unit is idle; the block does not enforce this.
//
// A pass-through octant is written into the queue on its accepting edge, then
// loaded from the queue head into the output register. Throughput: one input
// octant per cycle when it causes at most one result and the queue has room;
// an octant that flushes k held siblings occupies the back end for k extra
// results, so the rate is one result per cycle while the receiver is ready,
// set by the output register. The front stalls only when the two-entry
// command queue is full, the back end busy flushing or blocked by its receiver.
// Reset clears the run state, the queue and the output valid; the held
// store is not cleared, since each run writes its entries before reading.
module linear_octree_coarsen_unit #(
  parameter int COORD_BITS = 16,
  parameter int MAX_DIM    = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  loc_in_if.sink     in_i,
  loc_out_if.source  out_o,
  loc_cfg_if.sink    cfg_i
);
  localparam int OCT_BITS  = 3*COORD_BITS + loc_pkg::LEVEL_BITS;
  localparam int CMD_BITS  = $bits(loc_pkg::ctrl_t) + OCT_BITS;
  localparam int CMD_DEPTH = 2;

  logic [loc_pkg::DIM_BITS-1:0]   dimension_q;
  logic [loc_pkg::DEPTH_BITS-1:0] max_depth_q;
  loc_pkg::cfg_t                  cfg;

  logic                 push, pop, full, head_valid;
  loc_pkg::ctrl_t       push_ctrl, head_ctrl;
  logic [OCT_BITS-1:0]  push_oct, head_oct;
  logic [CMD_BITS-1:0]  head_data;

  // Configuration registers: always ready, decode by index, ignore others
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dimension_q <= loc_pkg::DIM_RESET;
      max_depth_q <= loc_pkg::MAX_DEPTH_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        loc_pkg::CFG_DIMENSION: dimension_q <= cfg_i.data[loc_pkg::DIM_BITS-1:0];
        loc_pkg::CFG_MAX_DEPTH: max_depth_q <= cfg_i.data[loc_pkg::DEPTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.dimension = dimension_q;
  assign cfg.max_depth = max_depth_q;

  // Front: classify each octant and issue a command
  loc_front #(
    .COORD_BITS (COORD_BITS),
    .MAX_DIM    (MAX_DIM)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .ctrl_o (push_ctrl),
    .oct_o  (push_oct)
  );

  // Decouple front and back so each side stalls on its own
  loc_queue #(
    .DATA_BITS (CMD_BITS),
    .DEPTH     (CMD_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  ({push_ctrl, push_oct}),
    .pop_i        (pop),
    .head_data_o  (head_data),
    .head_valid_o (head_valid),
    .full_o       (full)
  );

  assign head_ctrl = loc_pkg::ctrl_t'(head_data[CMD_BITS-1:OCT_BITS]);
  assign head_oct  = head_data[OCT_BITS-1:0];

  // Back: hold siblings, flush, merge, drive the result channel
  loc_back #(
    .COORD_BITS (COORD_BITS),
    .MAX_DIM    (MAX_DIM)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (head_valid),
    .head_ctrl_i  (head_ctrl),
    .head_oct_i   (head_oct),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

// ===== design/loc_queue.sv =====
// Short command queue between front and back of the coarsening unit.
// Generic storage; no package dependency.
module loc_queue #(
  parameter int DATA_BITS = 8,
  parameter int DEPTH     = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [DATA_BITS-1:0] push_data_i,
  input  logic                 pop_i,
  output logic [DATA_BITS-1:0] head_data_o,
  output logic                 head_valid_o,
  output logic                 full_o
);
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0] entry_q [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o       = (count_q == CNT_W'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/loc_front.sv =====
// Front end of the coarsening unit: accepts octants, tests for first
// children, tracks the run state and issues one command per octant.
// Depends on loc_pkg and loc_in_if.
module loc_front #(
  parameter int COORD_BITS = 16,
  parameter int MAX_DIM    = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  loc_pkg::cfg_t         cfg_i,
  loc_in_if.sink                in_i,
  input  logic                  full_i,
  output logic                  push_o,
  output loc_pkg::ctrl_t        ctrl_o,
  output logic [3*COORD_BITS+loc_pkg::LEVEL_BITS-1:0] oct_o
);
  localparam int CB    = loc_pkg::CNT_BITS;
  localparam int SLOTS = (1 << MAX_DIM) - 1;

  logic [CB-1:0]                  held_count_q, held_count_d;
  logic                           run_active_q, run_active_d;
  logic                           run_merged_q, run_merged_d;
  logic                           accept, eff3, first_child;
  logic [loc_pkg::DEPTH_BITS-1:0] pos;
  logic [COORD_BITS-1:0]          x_sh, y_sh, z_sh;
  logic [CB:0]                    siblings;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign push_o     = accept;
  assign oct_o      = {in_i.coord_x, in_i.coord_y, in_i.coord_z, in_i.level};

  // Any dimension code other than quadtree selects the full dimension
  assign eff3     = (MAX_DIM == 3) && (cfg_i.dimension != loc_pkg::DIM_QUADTREE);
  assign siblings = eff3 ? (CB + 1)'(8) : (CB + 1)'(4);

  assign pos  = (in_i.level >= cfg_i.max_depth) ? '0 : cfg_i.max_depth - in_i.level;
  assign x_sh = in_i.coord_x >> pos;
  assign y_sh = in_i.coord_y >> pos;
  assign z_sh = in_i.coord_z >> pos;

  always_comb begin
    if (32'(pos) >= COORD_BITS) begin
      first_child = 1'b1;
    end else begin
      first_child = !x_sh[0] && !y_sh[0] && !(eff3 && z_sh[0]);
    end
  end

  always_comb begin
    held_count_d     = held_count_q;
    run_active_d     = run_active_q;
    run_merged_d     = run_merged_q;
    ctrl_o.op        = loc_pkg::OP_PASS;
    ctrl_o.flush_cnt = '0;
    ctrl_o.slot      = '0;
    ctrl_o.eot       = in_i.end_of_tree;
    if (first_child) begin
      // Flush an unfinished run, then start a new one in entry zero
      ctrl_o.op        = loc_pkg::OP_HOLD;
      ctrl_o.flush_cnt = (run_active_q && !run_merged_q) ? held_count_q : '0;
      held_count_d     = CB'(1);
      run_active_d     = 1'b1;
      run_merged_d     = 1'b0;
    end else if (!run_active_q || run_merged_q) begin
      ctrl_o.op = loc_pkg::OP_PASS;
    end else if (({1'b0, held_count_q} + (CB + 1)'(1) >= siblings) ||
                 (held_count_q >= CB'(SLOTS))) begin
      ctrl_o.op    = loc_pkg::OP_PARENT;
      held_count_d = '0;
      run_merged_d = 1'b1;
    end else begin
      ctrl_o.op        = loc_pkg::OP_HOLD;
      ctrl_o.slot      = held_count_q;
      ctrl_o.flush_cnt = in_i.end_of_tree ? held_count_q : '0;
      held_count_d     = held_count_q + CB'(1);
    end
    // End of tree: the back end empties the store, so drop the run here
    if (in_i.end_of_tree) begin
      held_count_d = '0;
      run_active_d = 1'b0;
      run_merged_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count_q <= '0;
      run_active_q <= 1'b0;
      run_merged_q <= 1'b0;
    end else if (accept) begin
      held_count_q <= held_count_d;
      run_active_q <= run_active_d;
      run_merged_q <= run_merged_d;
    end
  end

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_active_q |-> held_count_q == '0)
    else $error("held count nonzero outside a run");

  a_merged_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_merged_q |-> run_active_q && held_count_q == '0)
    else $error("merged run still holds octants");

  a_open_run_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_active_q && !run_merged_q |-> held_count_q != '0)
    else $error("open run with empty store");

endmodule

// ===== design/loc_back.sv =====
// Back end of the coarsening unit: holds sibling octants, flushes them,
// forms parents and drives the output register.
// Depends on loc_pkg and loc_out_if.
module loc_back #(
  parameter int COORD_BITS = 16,
  parameter int MAX_DIM    = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  loc_pkg::cfg_t         cfg_i,
  input  logic                  head_valid_i,
  input  loc_pkg::ctrl_t        head_ctrl_i,
  input  logic [3*COORD_BITS+loc_pkg::LEVEL_BITS-1:0] head_oct_i,
  output logic                  pop_o,
  loc_out_if.source             out_o
);
  localparam int LB       = loc_pkg::LEVEL_BITS;
  localparam int CB       = loc_pkg::CNT_BITS;
  localparam int OCT_BITS = 3*COORD_BITS + LB;
  localparam int SLOTS    = (1 << MAX_DIM) - 1;
  localparam int IDX_BITS = $clog2(SLOTS);

  logic [OCT_BITS-1:0]   held_q [SLOTS];
  logic [CB-1:0]         idx_q, idx_d;
  logic                  out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] out_x_q, out_y_q, out_z_q;
  logic [LB-1:0]         out_level_q;
  logic                  out_merged_q, out_final_q;

  logic                  out_free, flushing, load, wr_en;
  logic [OCT_BITS-1:0]   ld_oct, rd_oct;
  logic                  ld_merged, ld_final;
  logic [CB-1:0]         rd_addr;
  logic [COORD_BITS-1:0] rd_x, rd_y, rd_z, keep;
  logic [LB-1:0]         rd_lev, par_lev;
  logic [loc_pkg::DEPTH_BITS-1:0] pos;
  logic [loc_pkg::DEPTH_BITS:0]   pos1;
  logic                  eff3;
  logic [OCT_BITS-1:0]   par_oct;

  assign out_free = !out_valid_q || out_o.ready;
  assign flushing = idx_q < head_ctrl_i.flush_cnt;

  // One read port: the flush index, or entry zero for a parent
  assign rd_addr = flushing ? idx_q : '0;
  assign rd_oct  = held_q[rd_addr[IDX_BITS-1:0]];
  assign rd_x    = rd_oct[OCT_BITS-1 -: COORD_BITS];
  assign rd_y    = rd_oct[2*COORD_BITS+LB-1 -: COORD_BITS];
  assign rd_z    = rd_oct[COORD_BITS+LB-1 -: COORD_BITS];
  assign rd_lev  = rd_oct[LB-1:0];

  // Parent of the first held sibling: clear bits at and below its level bit
  assign eff3    = (MAX_DIM == 3) && (cfg_i.dimension != loc_pkg::DIM_QUADTREE);
  assign pos     = (rd_lev >= cfg_i.max_depth) ? '0 : cfg_i.max_depth - rd_lev;
  assign pos1    = {1'b0, pos} + (loc_pkg::DEPTH_BITS + 1)'(1);
  assign keep    = {COORD_BITS{1'b1}} << pos1;
  assign par_lev = (rd_lev != '0) ? rd_lev - LB'(1) : '0;
  assign par_oct = {rd_x & keep, rd_y & keep, eff3 ? (rd_z & keep) : rd_z, par_lev};

  always_comb begin
    idx_d     = idx_q;
    pop_o     = 1'b0;
    load      = 1'b0;
    wr_en     = 1'b0;
    ld_oct    = head_oct_i;
    ld_merged = 1'b0;
    ld_final  = head_ctrl_i.eot;
    if (head_valid_i) begin
      if (flushing) begin
        // Emit held octants in order, one per cycle while the output register is free
        if (out_free) begin
          load     = 1'b1;
          ld_oct   = rd_oct;
          ld_final = 1'b0;
          idx_d    = idx_q + CB'(1);
        end
      end else begin
        case (head_ctrl_i.op)
          loc_pkg::OP_PASS: begin
            if (out_free) begin
              load  = 1'b1;
              pop_o = 1'b1;
            end
          end
          loc_pkg::OP_PARENT: begin
            if (out_free) begin
              load      = 1'b1;
              ld_oct    = par_oct;
              ld_merged = 1'b1;
              pop_o     = 1'b1;
            end
          end
          loc_pkg::OP_HOLD: begin
            if (!head_ctrl_i.eot || out_free) begin
              wr_en = 1'b1;
              load  = head_ctrl_i.eot;
              pop_o = 1'b1;
            end
          end
          default: begin
            pop_o = 1'b1;
          end
        endcase
      end
    end
    if (pop_o) begin
      idx_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_x_q      <= ld_oct[OCT_BITS-1 -: COORD_BITS];
      out_y_q      <= ld_oct[2*COORD_BITS+LB-1 -: COORD_BITS];
      out_z_q      <= ld_oct[COORD_BITS+LB-1 -: COORD_BITS];
      out_level_q  <= ld_oct[LB-1:0];
      out_merged_q <= ld_merged;
      out_final_q  <= ld_final;
    end
    if (wr_en) begin
      held_q[head_ctrl_i.slot[IDX_BITS-1:0]] <= head_oct_i;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_x     = out_x_q;
  assign out_o.out_y     = out_y_q;
  assign out_o.out_z     = out_z_q;
  assign out_o.out_level = out_level_q;
  assign out_o.merged    = out_merged_q;
  assign out_o.final_out = out_final_q;

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> idx_q <= head_ctrl_i.flush_cnt)
    else $error("flush index ran past the flush count");

  a_idx_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != '0 |-> head_valid_i)
    else $error("flush in progress without a command");

  a_pop_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == '0)
    else $error("flush index not cleared after a command");

endmodule
